// File: src/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator package
// Shared constants, operation and status codes, and memory write types.
// ----------------------------------------------------------------------------
package ffpa_pkg;

   // Pool geometry.
   localparam int POOL_BYTES   = 1024;
   localparam int HEADER_BYTES = 16;
   localparam int ADDR_W       = 10;
   localparam int LINK_W       = ADDR_W + 1;
   localparam int WALK_LIMIT   = POOL_BYTES / HEADER_BYTES;
   localparam int STEP_W       = 7;
   localparam int TOTAL_W      = 16;
   localparam int NUM_W        = 23;
   localparam int QUOT_W       = 7;

   localparam logic [LINK_W-1:0] LINK_NONE  = LINK_W'(POOL_BYTES);
   localparam logic [ADDR_W-1:0] RESET_SIZE = ADDR_W'(POOL_BYTES - HEADER_BYTES);

   // Operation codes.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_STATS = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NO_FIT    = 2'd1;
   localparam logic [1:0] ST_NULL_FREE = 2'd2;

   // Write request to the size store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] data;
   } size_wr_type;

   // Write request to the next-link store.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } next_wr_type;

endpackage

// File: src/ffpa_hdr_mem.sv
// ----------------------------------------------------------------------------
// Header memories
// Size and next-link stores, one read address, registered read data. Entry
// zero reads as the reset header until it is first written.
// ----------------------------------------------------------------------------
module ffpa_hdr_mem
   import ffpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] rd_addr,
   input  size_wr_type       size_wr,
   input  next_wr_type       next_wr,
   output logic [ADDR_W-1:0] rd_size,
   output logic [LINK_W-1:0] rd_next
);

   logic [ADDR_W-1:0] size_mem [POOL_BYTES];
   logic [LINK_W-1:0] next_mem [POOL_BYTES];
   logic [ADDR_W-1:0] size_q_ff;
   logic [LINK_W-1:0] next_q_ff;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              size0_valid_ff;
   logic              next0_valid_ff;

   // Memory arrays: one write and one read per store each cycle.
   always_ff @(posedge clock) begin
      if (size_wr.en) begin
         size_mem[size_wr.addr] <= size_wr.data;
      end
      if (next_wr.en) begin
         next_mem[next_wr.addr] <= next_wr.data;
      end
      size_q_ff  <= size_mem[rd_addr];
      next_q_ff  <= next_mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   // Entry zero holds the whole pool after reset until it is written.
   always_ff @(posedge clock) begin
      if (reset) begin
         size0_valid_ff <= 1'b0;
         next0_valid_ff <= 1'b0;
      end else begin
         if (size_wr.en && size_wr.addr == '0) begin
            size0_valid_ff <= 1'b1;
         end
         if (next_wr.en && next_wr.addr == '0) begin
            next0_valid_ff <= 1'b1;
         end
      end
   end

   assign rd_size = (rd_addr_ff == '0 && !size0_valid_ff) ? RESET_SIZE : size_q_ff;
   assign rd_next = (rd_addr_ff == '0 && !next0_valid_ff) ? LINK_NONE : next_q_ff;

endmodule

// File: src/ffpa_div.sv
// ----------------------------------------------------------------------------
// Fragmentation divider
// Restoring divider that yields one quotient bit per cycle. The quotient is
// known to stay below 128, so seven steps suffice.
// ----------------------------------------------------------------------------
module ffpa_div
   import ffpa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   numer,
   input  logic [TOTAL_W-1:0] denom,
   output logic               done,
   output logic [QUOT_W-1:0]  quot
);

   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [TOTAL_W-1:0] den_ff;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [2:0]         idx_ff;
   logic               run_ff;
   logic               done_ff;
   logic [NUM_W-1:0]   trial;

   // Shifted divisor for the current quotient bit.
   always_comb begin
      trial   = {{(NUM_W-TOTAL_W){1'b0}}, den_ff} << idx_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (rem_ff >= trial) begin
         rem_in          = rem_ff - trial;
         quot_in[idx_ff] = 1'b1;
      end
   end

   // Iteration control.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            idx_ff  <= 3'(QUOT_W - 1);
            rem_ff  <= numer;
            den_ff  <= denom;
            quot_ff <= '0;
         end else if (run_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            idx_ff  <= idx_ff - 3'd1;
            if (idx_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: src/first_fit_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator
// Free-list allocator over a 1024-byte pool with headers kept in memories.
// ----------------------------------------------------------------------------
// Usage: raise start with req_operation, req_request_size and req_block_offset
// while busy is low; the transaction is taken at that clock edge. Each
// transaction yields exactly one result, shown for one cycle with rsp_valid.
// The receiver cannot stall, so results are never held.
// Timing: a free, a null free or an unused operation answers in the next
// cycle and leaves busy low, as does an allocate or a stats query on an
// empty list. Otherwise an allocate passes a read state, walks the free-list
// headers one by one and ends in a split state, so its result shows in the
// cycle after that; a failed allocate answers right after the walk. A stats
// query passes a read state, the header walk, a multiply state and the
// seven-step divider, skipping the divider for a zero total. The header walk
// reads the header memories once per cycle and visits at most 64 headers.
// Reset: the free list becomes one block at offset zero spanning the pool
// less its header; no clearing pass is needed, entry zero is overlaid until
// first written.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top
   import ffpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic [9:0]        req_request_size,
   input  logic [9:0]        req_block_offset,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [9:0]        rsp_granted_offset,
   output logic [10:0]       rsp_total_free,
   output logic [10:0]       rsp_largest_free,
   output logic [6:0]        rsp_free_count,
   output logic [6:0]        rsp_fragmentation_percent
);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_WALK, S_SPLIT, S_MUL, S_DIV
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [LINK_W-1:0]  head_ff, head_in;
   logic [LINK_W-1:0]  cur_ff, cur_in;
   logic [LINK_W-1:0]  prev_ff, prev_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [ADDR_W-1:0]  req_ff, req_in;
   logic [ADDR_W-1:0]  nb_ff, nb_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [ADDR_W-1:0]  largest_ff, largest_in;
   logic [STEP_W-1:0]  count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [9:0]         rsp_granted_ff, rsp_granted_in;
   logic [10:0]        rsp_total_ff, rsp_total_in;
   logic [10:0]        rsp_largest_ff, rsp_largest_in;
   logic [6:0]         rsp_count_ff, rsp_count_in;
   logic [6:0]         rsp_frag_ff, rsp_frag_in;

   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  rd_size;
   logic [LINK_W-1:0]  rd_next;
   size_wr_type        size_wr;
   next_wr_type        next_wr;
   logic               div_start;
   logic               div_done;
   logic [QUOT_W-1:0]  div_quot;
   logic [NUM_W-1:0]   div_numer;

   logic [LINK_W-1:0]  need;
   logic [LINK_W:0]    nb_sum;
   logic               fits;
   logic [STEP_W-1:0]  steps_next;
   logic               walk_end;
   logic [10:0]        total_sat;

   ffpa_hdr_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .size_wr (size_wr),
      .next_wr (next_wr),
      .rd_size (rd_size),
      .rd_next (rd_next)
   );

   ffpa_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (total_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Fit test for the header currently read.
   assign need       = {1'b0, req_ff} + LINK_W'(HEADER_BYTES);
   assign nb_sum     = {2'b00, cur_ff[ADDR_W-1:0]} + {1'b0, need};
   assign fits       = ({1'b0, rd_size} >= need) && (nb_sum < (LINK_W+1)'(POOL_BYTES));
   assign steps_next = steps_ff + STEP_W'(1);
   assign walk_end   = (steps_next == STEP_W'(WALK_LIMIT)) || rd_next[ADDR_W];
   assign total_sat  = (total_ff > TOTAL_W'(2047)) ? 11'd2047 : total_ff[10:0];
   assign div_numer  = NUM_W'({{(NUM_W-TOTAL_W){1'b0}}, total_ff - {6'd0, largest_ff}}
                              * NUM_W'(100));

   // Sequencer: walks the list, splits blocks and forms the result.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      head_in        = head_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      steps_in       = steps_ff;
      req_in         = req_ff;
      nb_in          = nb_ff;
      total_in       = total_ff;
      largest_in     = largest_ff;
      count_in       = count_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = '0;
      rsp_granted_in = '0;
      rsp_total_in   = '0;
      rsp_largest_in = '0;
      rsp_count_in   = '0;
      rsp_frag_in    = '0;
      rd_addr        = cur_ff[ADDR_W-1:0];
      size_wr        = '0;
      next_wr        = '0;
      div_start      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = req_operation;
               req_in     = req_request_size;
               cur_in     = head_ff;
               prev_in    = LINK_NONE;
               steps_in   = '0;
               total_in   = '0;
               largest_in = '0;
               count_in   = '0;
               unique case (req_operation)
                  OP_ALLOC: begin
                     if (head_ff[ADDR_W]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NO_FIT;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  OP_FREE: begin
                     rsp_valid_in = 1'b1;
                     if (req_block_offset < ADDR_W'(HEADER_BYTES)) begin
                        rsp_status_in = ST_NULL_FREE;
                     end else begin
                        next_wr.en   = 1'b1;
                        next_wr.addr = req_block_offset - ADDR_W'(HEADER_BYTES);
                        next_wr.data = head_ff;
                        head_in      = {1'b0, req_block_offset - ADDR_W'(HEADER_BYTES)};
                        rsp_status_in = ST_OK;
                     end
                  end
                  OP_STATS: begin
                     if (head_ff[ADDR_W]) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_OK;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            steps_in = steps_next;
            cur_in   = rd_next;
            prev_in  = cur_ff;
            if (op_ff == OP_ALLOC) begin
               if (fits) begin
                  size_wr.en   = 1'b1;
                  size_wr.addr = nb_sum[ADDR_W-1:0];
                  size_wr.data = rd_size - need[ADDR_W-1:0];
                  next_wr.en   = 1'b1;
                  next_wr.addr = nb_sum[ADDR_W-1:0];
                  next_wr.data = rd_next;
                  nb_in        = nb_sum[ADDR_W-1:0];
                  cur_in       = cur_ff;
                  prev_in      = prev_ff;
                  state_in     = S_SPLIT;
               end else if (walk_end) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_NO_FIT;
                  state_in      = S_IDLE;
               end else begin
                  rd_addr = rd_next[ADDR_W-1:0];
               end
            end else begin
               total_in = total_ff + {6'd0, rd_size};
               if (rd_size > largest_ff) begin
                  largest_in = rd_size;
               end
               count_in = count_ff + STEP_W'(1);
               if (walk_end) begin
                  state_in = S_MUL;
               end else begin
                  rd_addr = rd_next[ADDR_W-1:0];
               end
            end
         end
         S_SPLIT: begin
            size_wr.en   = 1'b1;
            size_wr.addr = cur_ff[ADDR_W-1:0];
            size_wr.data = req_ff;
            if (prev_ff[ADDR_W]) begin
               head_in = {1'b0, nb_ff};
            end else begin
               next_wr.en   = 1'b1;
               next_wr.addr = prev_ff[ADDR_W-1:0];
               next_wr.data = {1'b0, nb_ff};
            end
            rsp_valid_in   = 1'b1;
            rsp_status_in  = ST_OK;
            rsp_granted_in = cur_ff[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
            state_in       = S_IDLE;
         end
         S_MUL: begin
            if (total_ff == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_total_in   = total_sat;
               rsp_largest_in = {1'b0, largest_ff};
               rsp_count_in   = count_ff;
               state_in       = S_IDLE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_total_in   = total_sat;
               rsp_largest_in = {1'b0, largest_ff};
               rsp_count_in   = count_ff;
               rsp_frag_in    = div_quot;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      cur_ff         <= cur_in;
      prev_ff        <= prev_in;
      steps_ff       <= steps_in;
      req_ff         <= req_in;
      nb_ff          <= nb_in;
      total_ff       <= total_in;
      largest_ff     <= largest_in;
      count_ff       <= count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_largest_ff <= rsp_largest_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_frag_ff    <= rsp_frag_in;
   end

   assign busy                      = (state_ff != S_IDLE);
   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = rsp_status_ff;
   assign rsp_granted_offset        = rsp_granted_ff;
   assign rsp_total_free            = rsp_total_ff;
   assign rsp_largest_free          = rsp_largest_ff;
   assign rsp_free_count            = rsp_count_ff;
   assign rsp_fragmentation_percent = rsp_frag_ff;

endmodule

// File: src/ffpa_checker.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module ffpa_checker
   import ffpa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [9:0]  rsp_granted_offset,
   input logic [10:0] rsp_total_free,
   input logic [10:0] rsp_largest_free,
   input logic [6:0]  rsp_free_count,
   input logic [6:0]  rsp_fragmentation_percent
);

   // An accepted transaction is answered at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_valid || busy)
      else $error("accepted transaction neither answered nor in progress");

   // A result is only shown once the block has finished its work.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   // A failed transaction carries no offset, free total or free count.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_granted_offset == '0 && rsp_total_free == '0 && rsp_free_count == '0)
      else $error("failed transaction carries data");

   // Fragmentation is a percentage of a nonzero free total.
   a_frag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fragmentation_percent != '0 |->
         rsp_fragmentation_percent <= 7'd100 && rsp_total_free != '0)
      else $error("fragmentation out of range");

   // An empty walk reports no free bytes.
   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_free_count == '0 |-> rsp_total_free == '0 &&
         rsp_largest_free == '0)
      else $error("free bytes reported without free blocks");

endmodule

bind first_fit_pool_allocator_top ffpa_checker u_ffpa_checker (
   .clock                     (clock),
   .reset                     (reset),
   .start                     (start),
   .busy                      (busy),
   .rsp_valid                 (rsp_valid),
   .rsp_status                (rsp_status),
   .rsp_granted_offset        (rsp_granted_offset),
   .rsp_total_free            (rsp_total_free),
   .rsp_largest_free          (rsp_largest_free),
   .rsp_free_count            (rsp_free_count),
   .rsp_fragmentation_percent (rsp_fragmentation_percent)
);

// File: sim/first_fit_pool_allocator_top_test.sv
// ----------------------------------------------------------------------------
// First-fit pool allocator testbench
// Drives allocate, free and stats transactions through the start/busy port
// and checks every result against a cycle-free model of the free list kept
// in a scoreboard. Frees that are not null use only offsets with a known header.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_top_test;
   import ffpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int         STALL_LIMIT = 5000;
   localparam int         RANDOM_ITEMS = 1900;

   // Expected contents of one result transaction.
   typedef struct {
      logic [1:0]  status;
      logic [9:0]  granted;
      logic [10:0] total;
      logic [10:0] largest;
      logic [6:0]  count;
      logic [6:0]  frag;
   } alloc_result_type;

   // Scoreboard: a private copy of the free list and the expected results.
   class pool_scoreboard;
      int               head;
      int               hdr_size [POOL_BYTES];
      int               hdr_next [POOL_BYTES];
      bit               hdr_known [POOL_BYTES];
      int               known_hdrs [$];
      int               live_grants [$];
      alloc_result_type results_due [$];
      int               errors;

      function new();
         head = 0;
         foreach (hdr_size[i]) begin
            hdr_size[i] = 0;
            hdr_next[i] = 0;
            hdr_known[i] = 0;
         end
         hdr_size[0] = POOL_BYTES - HEADER_BYTES;
         hdr_next[0] = POOL_BYTES;
         hdr_known[0] = 1;
         known_hdrs.push_back(0);
         errors = 0;
      endfunction

      function void mark_header(int h);
         if (!hdr_known[h]) begin
            hdr_known[h] = 1;
            known_hdrs.push_back(h);
         end
      endfunction

      // Work out the result of one accepted transaction and update the list.
      function void note_request(logic [1:0] op, logic [9:0] req, logic [9:0] off);
         alloc_result_type r;
         int cur, prev, need, nb, tot, big, cnt;
         r = '{default: '0};
         case (op)
            OP_ALLOC: begin
               cur = head;
               prev = POOL_BYTES;
               need = int'(req) + HEADER_BYTES;
               r.status = ST_NO_FIT;
               for (int s = 0; s < WALK_LIMIT && cur < POOL_BYTES; s++) begin
                  nb = cur + need;
                  if (hdr_size[cur] >= need && nb < POOL_BYTES) begin
                     hdr_size[nb] = hdr_size[cur] - need;
                     hdr_next[nb] = hdr_next[cur];
                     if (prev >= POOL_BYTES) head = nb;
                     else hdr_next[prev] = nb;
                     hdr_size[cur] = req;
                     mark_header(nb);
                     mark_header(cur);
                     live_grants.push_back(cur + HEADER_BYTES);
                     r.status = ST_OK;
                     r.granted = 10'(cur + HEADER_BYTES);
                     break;
                  end
                  prev = cur;
                  cur = hdr_next[cur];
               end
            end
            OP_FREE: begin
               if (off < HEADER_BYTES) begin
                  r.status = ST_NULL_FREE;
               end else begin
                  hdr_next[off - HEADER_BYTES] = head;
                  head = off - HEADER_BYTES;
                  r.status = ST_OK;
               end
            end
            OP_STATS: begin
               tot = 0;
               big = 0;
               cnt = 0;
               cur = head;
               for (int s = 0; s < WALK_LIMIT && cur < POOL_BYTES; s++) begin
                  tot += hdr_size[cur];
                  if (hdr_size[cur] > big) big = hdr_size[cur];
                  cnt++;
                  cur = hdr_next[cur];
               end
               r.status = ST_OK;
               r.total = (tot > 2047) ? 11'd2047 : 11'(tot);
               r.largest = (big > 2047) ? 11'd2047 : 11'(big);
               r.count = (cnt > 127) ? 7'd127 : 7'(cnt);
               r.frag = (tot > 0) ? 7'((100 * (tot - big)) / tot) : 7'd0;
            end
            default: ;
         endcase
         results_due.push_back(r);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // Compare one result transaction with the oldest expectation.
      task check_result(alloc_result_type got);
         alloc_result_type w;
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result", 1, 0);
         end else begin
            w = results_due.pop_front();
            if (got.status !== w.status) report_mismatch("status", got.status, w.status);
            if (got.granted !== w.granted) report_mismatch("granted", got.granted, w.granted);
            if (got.total !== w.total) report_mismatch("total", got.total, w.total);
            if (got.largest !== w.largest) report_mismatch("largest", got.largest, w.largest);
            if (got.count !== w.count) report_mismatch("count", got.count, w.count);
            if (got.frag !== w.frag) report_mismatch("frag", got.frag, w.frag);
         end
      endtask
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic [1:0] req_operation = '0;
   logic [9:0] req_request_size = '0;
   logic [9:0] req_block_offset = '0;
   logic       busy, rsp_valid;
   logic [1:0] rsp_status;
   logic [9:0] rsp_granted_offset;
   logic [10:0] rsp_total_free, rsp_largest_free;
   logic [6:0] rsp_free_count, rsp_fragmentation_percent;

   pool_scoreboard sb = new();
   bit             allow_gaps = 1;
   int             quiet_cycles = 0;

   first_fit_pool_allocator_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_request_size(req_request_size),
      .req_block_offset(req_block_offset), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_granted_offset(rsp_granted_offset),
      .rsp_total_free(rsp_total_free), .rsp_largest_free(rsp_largest_free),
      .rsp_free_count(rsp_free_count),
      .rsp_fragmentation_percent(rsp_fragmentation_percent)
   );

   always #5 clock = ~clock;

   // Collect each result transaction in the middle of its cycle.
   always @(negedge clock) begin
      alloc_result_type got;
      if (!reset && rsp_valid) begin
         got.status = rsp_status;
         got.granted = rsp_granted_offset;
         got.total = rsp_total_free;
         got.largest = rsp_largest_free;
         got.count = rsp_free_count;
         got.frag = rsp_fragmentation_percent;
         sb.check_result(got);
      end
   end

   // Watchdog on cycles in which no transaction moves either way.
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("first_fit_pool_allocator_top_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one request and hold it until it is taken.
   task send_request(logic [1:0] op, logic [9:0] req, logic [9:0] off);
      logic was_busy;
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_request_size <= req;
      req_block_offset <= off;
      // Busy is sampled mid-cycle; the edge after a low sample takes the request.
      do begin
         @(negedge clock);
         was_busy = busy;
         @(posedge clock);
      end while (was_busy);
      sb.note_request(op, req, off);
   endtask

   // Free a live grant if there is one, else a known header.
   task send_valid_free();
      int idx, h;
      if (sb.live_grants.size() > 0) begin
         idx = $urandom_range(0, sb.live_grants.size() - 1);
         h = sb.live_grants[idx];
         sb.live_grants.delete(idx);
      end else begin
         h = HEADER_BYTES;
      end
      send_request(OP_FREE, 10'($urandom), 10'(h));
   endtask

   initial begin
      int pick, h;
      logic [9:0] sz;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, null frees, unused operation and a bogus free.
      send_request(OP_STATS, 10'h3ff, 10'h3ff);
      send_request(OP_ALLOC, 10'd1023, 10'h3ff);
      send_request(OP_ALLOC, 10'd993, 10'd0);
      send_request(OP_ALLOC, 10'd992, 10'd0);
      send_request(OP_STATS, 10'd0, 10'd0);
      send_request(OP_ALLOC, 10'd0, 10'd0);
      send_request(OP_FREE, 10'h3ff, 10'd0);
      send_request(OP_FREE, 10'd0, 10'd15);
      send_request(OP_UNUSED, 10'h3ff, 10'h3ff);
      send_valid_free();
      send_valid_free();
      send_request(OP_STATS, 10'd0, 10'd0);
      send_request(OP_FREE, 10'd0, 10'd16);
      send_request(OP_FREE, 10'd0, 10'd16);
      send_request(OP_STATS, 10'd0, 10'd0);
      send_request(OP_ALLOC, 10'd0, 10'd0);
      send_request(OP_ALLOC, 10'd5, 10'd0);
      send_request(OP_STATS, 10'd0, 10'd0);

      // Random traffic, mostly alloc/free pairs on small sizes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n > RANDOM_ITEMS - 200) allow_gaps = 0;
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            case ($urandom_range(0, 19))
               0: sz = 10'($urandom);
               1, 2, 3: sz = 10'($urandom_range(0, 255));
               default: sz = 10'($urandom_range(0, 48));
            endcase
            send_request(OP_ALLOC, sz, 10'($urandom));
         end else if (pick < 80) begin
            send_valid_free();
         end else if (pick < 92) begin
            send_request(OP_STATS, 10'($urandom), 10'($urandom));
         end else if (pick < 96) begin
            send_request(OP_FREE, 10'($urandom), 10'($urandom_range(0, 15)));
         end else if (pick < 98) begin
            send_request(OP_UNUSED, 10'($urandom), 10'($urandom));
         end else begin
            // Bogus free of a header that has been written at some point.
            h = sb.known_hdrs[$urandom_range(0, sb.known_hdrs.size() - 1)];
            if (h < POOL_BYTES - HEADER_BYTES) send_request(OP_FREE, 10'($urandom), 10'(h + HEADER_BYTES));
            else send_request(OP_STATS, 10'd0, 10'd0);
         end
      end
      start <= 0;

      // Drain and let the block settle.
      while (sb.results_due.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("first_fit_pool_allocator_top_test: done, clean");
      end else begin
         $display("first_fit_pool_allocator_top_test: done, errors");
      end
      $finish;
   end

endmodule

// File: first_fit_pool_allocator_top.f
src/ffpa_pkg.sv
src/ffpa_hdr_mem.sv
src/ffpa_div.sv
src/first_fit_pool_allocator_top.sv
src/ffpa_checker.sv
sim/first_fit_pool_allocator_top_test.sv
